// ===== rtl/spq_pkg.sv =====
// spq_pkg: shared types, constants and status codes for the sorted priority queue.
// No dependencies; used by the interfaces, the cell, the top level and the checker.
`default_nettype none

package spq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int VALUE_W     = 32;
   localparam int PRI_W       = 8;
   localparam int FILL_W      = 5;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   // opcodes
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   // response status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic [PRI_W-1:0]          prio;
   } entry_type;

   // broadcast from the control to every cell
   typedef struct packed {
      logic      ins;
      logic      rem;
      entry_type item;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ===== rtl/spq_if.sv =====
// spq_req_if / spq_rsp_if: valid/ready channels carrying request and response words.
// Depends on spq_pkg for field widths.
`default_nettype none

interface spq_req_if;
   logic                               valid;
   logic                               ready;
   logic                               opcode;
   logic signed [spq_pkg::VALUE_W-1:0] item_value;
   logic [spq_pkg::PRI_W-1:0]          item_priority;

   modport source (output valid, output opcode, output item_value, output item_priority,
                   input ready);
   modport sink   (input valid, input opcode, input item_value, input item_priority,
                   output ready);
endinterface

interface spq_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [spq_pkg::VALUE_W-1:0] out_value;
   logic [1:0]                         status;
   logic [spq_pkg::FILL_W-1:0]         fill_count;

   modport source (output valid, output out_value, output status, output fill_count,
                   input ready);
   modport sink   (input valid, input out_value, input status, input fill_count,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/sorted_priority_queue.sv =====
// sorted_priority_queue: bounded priority queue built as a chain of sorted cells.
// Depends on spq_pkg, spq_req_if / spq_rsp_if and spq_cell.
//
//   channel | dir | word fields                              | handshake
//   --------+-----+------------------------------------------+------------------
//   req_ch  | in  | opcode, item_value, item_priority        | valid/ready
//   rsp_ch  | out | out_value, status, fill_count            | valid/ready
//
// Cycles: one request word per cycle while req_ready is high; its response appears the cycle after accept.
// The chain updates every cell in the accept cycle: an insert is placed by comparing
// its priority in all cells at once, a remove shifts every cell one step to the head.
// Reset (synchronous) empties the queue via the count; cell contents are left as is.
// Stalls: req_ready drops while a response waits and rsp_ready is low, and during reset.
`default_nettype none

module sorted_priority_queue (
   input  wire logic  clock,
   input  wire logic  reset,
   spq_req_if.sink    req_ch,
   spq_rsp_if.source  rsp_ch
);

   localparam int DEPTH = spq_pkg::QUEUE_DEPTH;
   localparam int CW    = spq_pkg::CNT_W;

   spq_pkg::entry_type     entries [DEPTH];
   logic                   keeps   [DEPTH];
   spq_pkg::cell_ctrl_type ctrl;

   logic [CW-1:0]                      count_ff, count_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic signed [spq_pkg::VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic [1:0]                         rsp_status_ff, rsp_status_in;
   logic [spq_pkg::FILL_W-1:0]         rsp_fill_ff, rsp_fill_in;

   logic accept, is_insert, full, empty;

   // output register frees up whenever the sink takes it
   assign req_ch.ready = !reset && (!rsp_valid_ff || rsp_ch.ready);
   assign accept       = req_ch.valid && req_ch.ready;
   assign is_insert    = (req_ch.opcode == spq_pkg::OP_INSERT);
   assign full         = (count_ff == CW'(DEPTH));
   assign empty        = (count_ff == '0);

   // broadcast to the chain
   assign ctrl.ins        = accept && is_insert && !full;
   assign ctrl.rem        = accept && !is_insert && !empty;
   assign ctrl.item.value = req_ch.item_value;
   assign ctrl.item.prio  = req_ch.item_priority;

   // cell chain: cell 0 is the head
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic               left_keep;
      spq_pkg::entry_type left_entry, right_entry;

      if (i == 0) begin : g_head
         assign left_keep  = 1'b1;
         assign left_entry = ctrl.item;
      end else begin : g_mid
         assign left_keep  = keeps[i-1];
         assign left_entry = entries[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_entry = ctrl.item;   // slot leaves the occupied range anyway
      end else begin : g_body
         assign right_entry = entries[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .occupied    (CW'(i) < count_ff),
         .left_keep   (left_keep),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .entry_ff    (entries[i]),
         .keep        (keeps[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.ins) begin
         count_in = count_ff + CW'(1);
      end else if (ctrl.rem) begin
         count_in = count_ff - CW'(1);
      end
   end

   // response word
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_fill_in   = rsp_fill_ff;
      if (accept) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = '0;
         rsp_status_in = spq_pkg::ST_OK;
         rsp_fill_in   = spq_pkg::FILL_W'(count_in);
         if (is_insert && full) begin
            rsp_status_in = spq_pkg::ST_FULL;
         end else if (!is_insert && empty) begin
            rsp_status_in = spq_pkg::ST_EMPTY;
         end else if (!is_insert) begin
            rsp_value_in  = entries[0].value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_fill_ff   <= rsp_fill_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.out_value  = rsp_value_ff;
   assign rsp_ch.status     = rsp_status_ff;
   assign rsp_ch.fill_count = rsp_fill_ff;

endmodule

`default_nettype wire

// ===== rtl/spq_cell.sv =====
// spq_cell: one slot of the sorted chain; holds an entry and trades with its neighbors.
// Depends on spq_pkg.
`default_nettype none

module spq_cell (
   input  wire logic                   clock,
   input  wire spq_pkg::cell_ctrl_type ctrl,
   input  wire logic                   occupied,
   input  wire logic                   left_keep,
   input  wire spq_pkg::entry_type     left_entry,
   input  wire spq_pkg::entry_type     right_entry,
   output spq_pkg::entry_type          entry_ff,
   output logic                        keep
);

   spq_pkg::entry_type entry_in;

   // entry stays in place on insert if it ranks at or above the new one
   assign keep = occupied && (entry_ff.prio >= ctrl.item.prio);

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.rem) begin
         entry_in = right_entry;
      end else if (ctrl.ins && !keep) begin
         entry_in = left_keep ? ctrl.item : left_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

`default_nettype wire

// ===== rtl/spq_checker.sv =====
// spq_checker: port-level assertions for sorted_priority_queue, bound to the top level.
// Depends on spq_pkg and the top level's channel interfaces.
`default_nettype none

module spq_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_valid,
   input wire logic                               req_ready,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_ready,
   input wire logic signed [spq_pkg::VALUE_W-1:0] rsp_value,
   input wire logic [1:0]                         rsp_status,
   input wire logic [spq_pkg::FILL_W-1:0]         rsp_fill
);

   // stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value)
                                 && $stable(rsp_status) && $stable(rsp_fill))
      else $error("response word changed while stalled");

   // every accepted request answers in the next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("no response after accepted request");

   // empty remove reports an empty queue and no value
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == spq_pkg::ST_EMPTY |-> rsp_fill == '0 && rsp_value == '0)
      else $error("empty status with nonzero fill or value");

   // dropped insert only when the queue is full
   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == spq_pkg::ST_FULL
         |-> rsp_fill == spq_pkg::FILL_W'(spq_pkg::QUEUE_DEPTH) && rsp_value == '0)
      else $error("full status with wrong fill or value");

   // no response word pending right after a reset cycle
   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_value  (rsp_ch.out_value),
   .rsp_status (rsp_ch.status),
   .rsp_fill   (rsp_ch.fill_count)
);

`default_nettype wire
